>>> design/per_channel_trimmed_mean_adc_filter_assert.svh
`ifndef PER_CHANNEL_TRIMMED_MEAN_ADC_FILTER_ASSERT_SVH
`define PER_CHANNEL_TRIMMED_MEAN_ADC_FILTER_ASSERT_SVH

// check outside reset
`define PTM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("trimmed mean filter check failed");

// check at every edge, reset included
`define PTM_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("trimmed mean filter check failed");

`endif

>>> design/ptm_pkg.sv
package ptm_pkg;

	localparam int CHAN_W    = 3;
	localparam int VALUE_W   = 16;
	localparam int SUM_W     = 22;
	localparam int CNT_W     = 7;
	localparam int TRIM_DROP = 2;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [SUM_W-1:0]   sum;
		logic [VALUE_W-1:0] lo;
		logic [VALUE_W-1:0] hi;
	} chan_entry_t;

	localparam chan_entry_t ENTRY_RESET = '{
		count: '0,
		sum:   '0,
		lo:    '1,
		hi:    '0
	};

	typedef struct packed {
		logic              valid;
		logic [CHAN_W-1:0] channel;
		logic [SUM_W-1:0]  mid;
	} div_req_t;

endpackage

>>> design/ptm_chan_mem.sv
module ptm_chan_mem
	import ptm_pkg::*;
#(
	parameter int NUM_CHANNELS       = 8,
	parameter int SAMPLES_PER_RESULT = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CHAN_W-1:0]  channel,
	input  logic [VALUE_W-1:0] sample,
	output div_req_t           req,
	input  logic               req_ready
);

	localparam int DEPTH = (NUM_CHANNELS < (1 << CHAN_W)) ? NUM_CHANNELS : (1 << CHAN_W);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] N_CNT = CNT_W'(SAMPLES_PER_RESULT);

	chan_entry_t         mem_q [DEPTH];
	logic [DEPTH-1:0]    vld_q;
	chan_entry_t         rd_q;

	logic                valid_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic [VALUE_W-1:0]  sample_s1;

	logic                wr_valid_q;
	logic [AW-1:0]       wr_idx_q;
	chan_entry_t         wr_q;

	logic                take;
	logic [AW-1:0]       idx_s1;
	chan_entry_t         cur;
	chan_entry_t         nxt;
	logic                emit;
	logic                go;
	logic                wr_en;
	logic [SUM_W-1:0]    ends;

	assign idx_s1   = chan_s1[AW-1:0];
	assign take     = in_valid && !in_stall && (int'(channel) < NUM_CHANNELS);
	assign emit     = cur.count >= N_CNT;
	assign go       = !emit || req_ready;
	assign wr_en    = valid_s1 && go;
	assign in_stall = valid_s1 && !go;

	always_comb begin
		priority if (wr_valid_q && wr_idx_q == idx_s1) begin
			cur = wr_q;
		end else if (vld_q[idx_s1]) begin
			cur = rd_q;
		end else begin
			cur = ENTRY_RESET;
		end
	end

	always_comb begin
		nxt       = cur;
		nxt.sum   = cur.sum + {{(SUM_W-VALUE_W){1'b0}}, sample_s1};
		nxt.count = cur.count + CNT_W'(1);
		if (sample_s1 < cur.lo) begin
			nxt.lo = sample_s1;
		end
		if (sample_s1 > cur.hi) begin
			nxt.hi = sample_s1;
		end
		if (emit) begin
			nxt = ENTRY_RESET;
		end
	end

	assign ends        = SUM_W'({1'b0, cur.lo} + {1'b0, cur.hi});
	assign req.valid   = valid_s1 && emit;
	assign req.channel = chan_s1;
	assign req.mid     = (cur.sum >= ends) ? (cur.sum - ends) : '0;

	always_ff @(posedge clk) begin
		if (take) begin
			rd_q <= mem_q[channel[AW-1:0]];
		end
		if (wr_en) begin
			mem_q[idx_s1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			vld_q      <= '0;
			wr_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (wr_en) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				vld_q[idx_s1] <= 1'b1;
				wr_valid_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			chan_s1   <= channel;
			sample_s1 <= sample;
		end
		if (wr_en) begin
			wr_idx_q <= idx_s1;
			wr_q     <= nxt;
		end
	end

endmodule

>>> design/ptm_div.sv
module ptm_div
	import ptm_pkg::*;
#(
	parameter int SAMPLES_PER_RESULT = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	output logic               req_ready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CHAN_W-1:0]  result_channel,
	output logic [VALUE_W-1:0] filtered_value
);

	localparam int DIVISOR = SAMPLES_PER_RESULT - TRIM_DROP;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int DIV_W   = $clog2(DIVISOR + 1);
	localparam int BACK_W  = SUM_W + DIV_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'((2 ** SUM_W) / DIVISOR);
	localparam logic [DIV_W-1:0]   DIV_C   = DIV_W'(DIVISOR);

	logic               valid_s2;
	logic [CHAN_W-1:0]  chan_s2;
	logic [SUM_W-1:0]   mid_s2;

	logic               valid_s3;
	logic [CHAN_W-1:0]  chan_s3;
	logic [SUM_W-1:0]   mid_s3;
	logic [SUM_W-1:0]   quot_s3;

	logic               out_valid_q;
	logic [CHAN_W-1:0]  chan_q;
	logic [VALUE_W-1:0] value_q;

	logic               out_free;
	logic               free_s3;
	logic [PROD_W-1:0]  prod;
	logic [BACK_W-1:0]  back;
	logic [SUM_W-1:0]   rem;
	logic [SUM_W-1:0]   quot_fix;
	logic [VALUE_W-1:0] mean;

	assign out_free  = !out_valid_q || !out_stall;
	assign free_s3   = !valid_s3 || out_free;
	assign req_ready = !valid_s2 || free_s3;

	assign prod     = PROD_W'(mid_s2) * PROD_W'(RECIP_C);
	assign back     = BACK_W'(quot_s3) * BACK_W'(DIV_C);
	assign rem      = mid_s3 - back[SUM_W-1:0];
	assign quot_fix = quot_s3 + SUM_W'(rem >= SUM_W'(DIV_C));
	assign mean     = (quot_fix > SUM_W'({VALUE_W{1'b1}})) ? '1 : quot_fix[VALUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s2 <= req.valid;
			end
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req.valid) begin
			chan_s2 <= req.channel;
			mid_s2  <= req.mid;
		end
		if (free_s3 && valid_s2) begin
			chan_s3 <= chan_s2;
			mid_s3  <= mid_s2;
			quot_s3 <= prod[SUM_W +: SUM_W];
		end
		if (out_free && valid_s3) begin
			chan_q  <= chan_s3;
			value_q <= mean;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_channel = chan_q;
	assign filtered_value = value_q;

endmodule

>>> design/per_channel_trimmed_mean_adc_filter.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  channel[2:0], sample[15:0]
// out      output     out_valid/out_stall  result_channel[2:0], filtered_value[15:0]
//
// One transaction per cycle while in_stall is low; the channel state memory is read at
// accept and written back when the s1 stage advances, with the last write forwarded.
// A result passes the s1, s2 and s3 stages and the output register, through a reciprocal
// multiply and one correction step.
// Reset clears all per-channel state at once through per-entry valid bits.
// in_stall rises only when a result must enter a full, stalled output path.
module per_channel_trimmed_mean_adc_filter
	import ptm_pkg::*;
#(
	parameter int NUM_CHANNELS       = 8,
	parameter int SAMPLES_PER_RESULT = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CHAN_W-1:0]  channel,
	input  logic [VALUE_W-1:0] sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CHAN_W-1:0]  result_channel,
	output logic [VALUE_W-1:0] filtered_value
);

	div_req_t req;
	logic     req_ready;

	ptm_chan_mem #(
		.NUM_CHANNELS       (NUM_CHANNELS),
		.SAMPLES_PER_RESULT (SAMPLES_PER_RESULT)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.channel   (channel),
		.sample    (sample),
		.req       (req),
		.req_ready (req_ready)
	);

	ptm_div #(
		.SAMPLES_PER_RESULT (SAMPLES_PER_RESULT)
	) u_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.req_ready      (req_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_channel (result_channel),
		.filtered_value (filtered_value)
	);

endmodule

>>> design/ptm_checker.sv
`include "per_channel_trimmed_mean_adc_filter_assert.svh"

module ptm_checker
	import ptm_pkg::*;
#(
	parameter int NUM_CHANNELS = 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [CHAN_W-1:0]  result_channel,
	input logic [VALUE_W-1:0] filtered_value
);

	logic [CHAN_W+VALUE_W-1:0] out_data;

	assign out_data = {result_channel, filtered_value};

	`PTM_ASSERT_ALWAYS(a_no_out_in_reset, clk, !arst_n |-> !out_valid)
	`PTM_ASSERT(a_stall_needs_full_out, clk, arst_n, in_stall |-> out_valid && out_stall)
	`PTM_ASSERT(a_chan_in_range, clk, arst_n, out_valid |-> int'(result_channel) < NUM_CHANNELS)
	`PTM_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid)
	`PTM_ASSERT(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable(out_data))

endmodule

bind per_channel_trimmed_mean_adc_filter ptm_checker #(
	.NUM_CHANNELS (NUM_CHANNELS)
) u_ptm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.result_channel (result_channel),
	.filtered_value (filtered_value)
);

>>> dv/tb_per_channel_trimmed_mean_adc_filter.sv
module tb_per_channel_trimmed_mean_adc_filter;
	import ptm_pkg::*;

	localparam int NUM_CH     = 8;
	localparam int WINDOW     = 10;
	localparam int NUM_RANDOM = 1100;
	localparam int MAX_GAP    = 11;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 400;

	typedef struct {
		logic [CHAN_W-1:0]  chan;
		logic [VALUE_W-1:0] value;
		int                 gap;
	} adc_item_t;

	typedef struct {
		logic [CHAN_W-1:0]  chan;
		logic [VALUE_W-1:0] mean;
	} trimmed_mean_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_stall;
	logic [CHAN_W-1:0]  channel        = '0;
	logic [VALUE_W-1:0] sample         = '0;
	logic               out_valid;
	logic               out_stall      = 1'b0;
	logic [CHAN_W-1:0]  result_channel;
	logic [VALUE_W-1:0] filtered_value;

	adc_item_t     pending_samples[$];
	trimmed_mean_t expected_means[$];
	adc_item_t     on_bus;
	int            gap_cnt    = 0;
	int            sent_cnt   = 0;
	int            stall_left = 0;
	int            mismatches = 0;
	int            cyc        = 0;
	logic          hold_off   = 1'b0;

	logic [CNT_W-1:0]   win_count [NUM_CH];
	logic [SUM_W-1:0]   win_sum   [NUM_CH];
	logic [VALUE_W-1:0] win_lo    [NUM_CH];
	logic [VALUE_W-1:0] win_hi    [NUM_CH];

	per_channel_trimmed_mean_adc_filter #(
		.NUM_CHANNELS      (NUM_CH),
		.SAMPLES_PER_RESULT(WINDOW)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.channel       (channel),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_channel(result_channel),
		.filtered_value(filtered_value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic clear_window(input int c);
		win_count[c] = '0;
		win_sum[c]   = '0;
		win_lo[c]    = '1;
		win_hi[c]    = '0;
	endtask

	task automatic accumulate_sample(input adc_item_t it);
		int                 c;
		logic [SUM_W-1:0]   ends;
		logic [SUM_W-1:0]   mid;
		logic [SUM_W-1:0]   quot;
		trimmed_mean_t      r;
		c = int'(it.chan);
		if (c >= NUM_CH) return;
		if (win_count[c] < WINDOW) begin
			win_sum[c] = win_sum[c] + SUM_W'(it.value);
			if (it.value < win_lo[c]) win_lo[c] = it.value;
			if (it.value > win_hi[c]) win_hi[c] = it.value;
			win_count[c] = win_count[c] + 1'b1;
			return;
		end
		ends = SUM_W'(win_lo[c]) + SUM_W'(win_hi[c]);
		mid  = (win_sum[c] >= ends) ? win_sum[c] - ends : '0;
		quot = mid / SUM_W'((WINDOW > TRIM_DROP) ? WINDOW - TRIM_DROP : 1);
		r.chan = it.chan;
		r.mean = (quot > SUM_W'({VALUE_W{1'b1}})) ? '1 : quot[VALUE_W-1:0];
		expected_means.push_back(r);
		clear_window(c);
	endtask

	function automatic logic [VALUE_W-1:0] draw_sample();
		case ($urandom_range(0, 5))
			0:       return '1;
			1:       return '0;
			2:       return VALUE_W'($urandom_range(0, 15));
			3:       return 16'hFFF0 | VALUE_W'($urandom_range(0, 15));
			default: return VALUE_W'($urandom());
		endcase
	endfunction

	task automatic queue_sample(input int c, input logic [VALUE_W-1:0] v, input int gap);
		adc_item_t it;
		it.chan  = CHAN_W'(c);
		it.value = v;
		it.gap   = gap;
		pending_samples.push_back(it);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_cnt = 0;
		end else begin
			if (in_valid && !in_stall) begin
				accumulate_sample(on_bus);
				sent_cnt++;
			end
			if (in_valid && in_stall) begin
				// hold
			end else if (pending_samples.size() == 0) begin
				in_valid <= 1'b0;
			end else if (gap_cnt < pending_samples[0].gap) begin
				in_valid <= 1'b0;
				gap_cnt++;
			end else begin
				on_bus = pending_samples.pop_front();
				gap_cnt = 0;
				in_valid <= 1'b1;
				channel  <= on_bus.chan;
				sample   <= on_bus.value;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		trimmed_mean_t want;
		cyc++;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_means.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: channel %0d value %0d",
						result_channel, filtered_value);
			end else begin
				want = expected_means.pop_front();
				if (result_channel !== want.chan || filtered_value !== want.mean) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected channel %0d value %0d, got channel %0d value %0d",
							want.chan, want.mean, result_channel, filtered_value);
				end
			end
			stall_left = (cyc % 1024 >= 768) ? 0 : $urandom_range(0, MAX_GAP);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		out_stall <= hold_off || (stall_left > 0);
	end

	// long receiver hold-off while the sender keeps pushing
	initial begin
		while (sent_cnt < HOLD_AT) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#400000;
		$display("per_channel_trimmed_mean_adc_filter regression: fail");
		$finish;
	end

	initial begin
		int c;
		int gap;
		for (int i = 0; i < NUM_CH; i++) clear_window(i);

		// full-scale window on channel 0, rail-to-rail window on channel 7
		for (int i = 0; i < WINDOW; i++) begin
			queue_sample(0, '1, $urandom_range(0, MAX_GAP));
			queue_sample(NUM_CH - 1, (i % 2) ? '1 : '0, $urandom_range(0, MAX_GAP));
		end
		// trigger items; their samples are discarded
		queue_sample(0, 16'h1234, $urandom_range(0, MAX_GAP));
		queue_sample(NUM_CH - 1, 16'hEDCB, $urandom_range(0, MAX_GAP));

		c = 0;
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if ($urandom_range(0, 3) != 0) c = $urandom_range(0, NUM_CH - 1);
			if ((i >= HOLD_AT - 30 && i < HOLD_AT + 250) || (i / 100) % 3 == 2)
				gap = 0;
			else
				gap = $urandom_range(0, MAX_GAP);
			queue_sample(c, draw_sample(), gap);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_samples.size() > 0 || in_valid) @(posedge clk);
		while (expected_means.size() > 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0 && expected_means.size() == 0) begin
			$display("per_channel_trimmed_mean_adc_filter regression: pass");
		end else begin
			$display("per_channel_trimmed_mean_adc_filter regression: fail");
		end
		$finish;
	end

endmodule

>>> per_channel_trimmed_mean_adc_filter.f
+incdir+design
design/ptm_pkg.sv
design/ptm_chan_mem.sv
design/ptm_div.sv
design/per_channel_trimmed_mean_adc_filter.sv
design/ptm_checker.sv
dv/tb_per_channel_trimmed_mean_adc_filter.sv
